// ===== sv/emd_pkg.sv =====
package emd_pkg;

   localparam int MAX_MARKER_DEFAULT = 4;

   localparam int CFG_LEN_W  = 3;
   localparam int CFG_DATA_W = 32;
   localparam int BYTE_W     = 8;

   localparam logic [CFG_LEN_W-1:0]  MARKER_LENGTH_RESET = 3'd1;
   localparam logic [CFG_DATA_W-1:0] MARKER_BYTES_RESET  = 32'd10;

   localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;

   typedef enum logic [0:0] {
      CSR_MARKER_LENGTH = 1'b0,
      CSR_MARKER_BYTES  = 1'b1
   } csr_index_type;

endpackage

// ===== sv/end_marker_message_deframer_top.sv =====
// An accepted byte is held in the result list, then moved to the rsp_* output register.
// Throughput, while rsp_stall is low: one byte per cycle if each byte yields at most one
// result; a byte that releases held marker bytes yields up to MAX_MARKER results, one per
// cycle, and req_stall is high until the last of them has moved to the output register.
// Reset clears the match count, the pending zero skip and both result stages, and sets the
// marker to a single LF byte.
module end_marker_message_deframer_top #(
   parameter int MAX_MARKER = emd_pkg::MAX_MARKER_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [emd_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                            req_chunk_last,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [emd_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                            rsp_is_end,

   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_index,
   input  logic [emd_pkg::CFG_DATA_W-1:0]  csr_data
);

   localparam int CNT_W = (MAX_MARKER > 1) ? $clog2(MAX_MARKER) : 1;
   localparam int LEN_W = $clog2(MAX_MARKER + 1);
   localparam int EXT_W = emd_pkg::BYTE_W * MAX_MARKER + emd_pkg::CFG_DATA_W;

   logic [emd_pkg::CFG_LEN_W-1:0]  marker_length_ff;
   logic [emd_pkg::CFG_DATA_W-1:0] marker_bytes_ff;
   logic [CNT_W-1:0]               match_count_ff, match_count_in;
   logic                           skip_pend_ff, skip_pend_in;

   logic                           list_vld_ff, list_vld_in;
   logic [CNT_W-1:0]               list_nheld_ff, list_nheld_in;
   logic                           list_tail_ff, list_tail_in;
   logic [emd_pkg::BYTE_W-1:0]     list_tail_byte_ff, list_tail_byte_in;
   logic                           list_tail_end_ff, list_tail_end_in;
   logic [CNT_W-1:0]               list_idx_ff, list_idx_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [emd_pkg::BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                           rsp_end_ff, rsp_end_in;

   logic [EXT_W-1:0]               marker_ext;
   logic [LEN_W-1:0]               eff_len;
   logic                           req_take;
   logic                           drop, flush, hit, done;
   logic [CNT_W-1:0]               cmp_idx;
   logic [LEN_W-1:0]               hit_cnt;
   logic                           out_free, load, entry_last, list_done;
   logic [emd_pkg::BYTE_W-1:0]     entry_byte;
   logic                           entry_end;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_length_ff <= emd_pkg::MARKER_LENGTH_RESET;
         marker_bytes_ff  <= emd_pkg::MARKER_BYTES_RESET;
      end else if (csr_valid) begin
         unique case (emd_pkg::csr_index_type'(csr_index))
            emd_pkg::CSR_MARKER_LENGTH: marker_length_ff <= csr_data[emd_pkg::CFG_LEN_W-1:0];
            emd_pkg::CSR_MARKER_BYTES:  marker_bytes_ff  <= csr_data;
         endcase
      end
   end

   // Marker bytes past the fourth read as zero.
   assign marker_ext = {{(emd_pkg::BYTE_W * MAX_MARKER){1'b0}}, marker_bytes_ff};

   always_comb begin
      if (marker_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (int'(marker_length_ff) > MAX_MARKER) begin
         eff_len = LEN_W'(MAX_MARKER);
      end else begin
         eff_len = LEN_W'(marker_length_ff);
      end
   end

   assign req_take = req_valid && !req_stall;

   // Per-byte step: the result list is a count of released marker bytes plus an optional
   // final entry, which is either the current byte or an end-of-message.
   always_comb begin
      drop    = skip_pend_ff && (req_in_byte == emd_pkg::ZERO_BYTE);
      flush   = LEN_W'(match_count_ff) >= eff_len;
      cmp_idx = flush ? '0 : match_count_ff;
      hit     = req_in_byte == marker_ext[emd_pkg::BYTE_W * cmp_idx +: emd_pkg::BYTE_W];
      hit_cnt = LEN_W'(cmp_idx) + LEN_W'(1);
      done    = hit && (hit_cnt == eff_len);

      list_nheld_in     = (drop || (!flush && hit)) ? '0 : match_count_ff;
      list_tail_in      = !drop && (!hit || done);
      list_tail_byte_in = done ? emd_pkg::ZERO_BYTE : req_in_byte;
      list_tail_end_in  = done;

      if (drop) begin
         match_count_in = match_count_ff;
      end else if (hit && !done) begin
         match_count_in = CNT_W'(hit_cnt);
      end else begin
         match_count_in = '0;
      end
      skip_pend_in = !drop && done && !req_chunk_last;
   end

   // Draining of the result list into the output register.
   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      load       = list_vld_ff && out_free;
      entry_last = list_tail_ff ? (list_idx_ff == list_nheld_ff)
                                : (list_idx_ff == list_nheld_ff - CNT_W'(1));
      list_done  = load && entry_last;
      if (list_idx_ff < list_nheld_ff) begin
         entry_byte = marker_ext[emd_pkg::BYTE_W * list_idx_ff +: emd_pkg::BYTE_W];
         entry_end  = 1'b0;
      end else begin
         entry_byte = list_tail_byte_ff;
         entry_end  = list_tail_end_ff;
      end

      req_stall = list_vld_ff && !list_done;

      if (req_take) begin
         list_vld_in = (list_nheld_in != '0) || list_tail_in;
         list_idx_in = '0;
      end else if (list_done) begin
         list_vld_in = 1'b0;
         list_idx_in = list_idx_ff;
      end else if (load) begin
         list_vld_in = 1'b1;
         list_idx_in = list_idx_ff + CNT_W'(1);
      end else begin
         list_vld_in = list_vld_ff;
         list_idx_in = list_idx_ff;
      end

      if (out_free) begin
         rsp_valid_in = load;
         rsp_byte_in  = entry_byte;
         rsp_end_in   = entry_end;
      end else begin
         rsp_valid_in = rsp_valid_ff;
         rsp_byte_in  = rsp_byte_ff;
         rsp_end_in   = rsp_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_count_ff <= '0;
         skip_pend_ff   <= 1'b0;
         list_vld_ff    <= 1'b0;
         list_idx_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_take) begin
            match_count_ff <= match_count_in;
            skip_pend_ff   <= skip_pend_in;
         end
         list_vld_ff  <= list_vld_in;
         list_idx_ff  <= list_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         list_nheld_ff     <= list_nheld_in;
         list_tail_ff      <= list_tail_in;
         list_tail_byte_ff <= list_tail_byte_in;
         list_tail_end_ff  <= list_tail_end_in;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_is_end   = rsp_end_ff;

endmodule

// ===== tb/end_marker_message_deframer_top_test.sv =====
module end_marker_message_deframer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 26;
   localparam int MAX_GAP       = 17;

   typedef struct {
      logic [emd_pkg::BYTE_W-1:0] data;
      logic                       is_end;
   } frame_item_type;

   class deframer_scoreboard;
      logic [emd_pkg::CFG_LEN_W-1:0]  marker_length;
      logic [emd_pkg::CFG_DATA_W-1:0] marker_bytes;
      int unsigned                    held_count;
      bit                             skip_zero;
      frame_item_type                 expected_q[$];
      int                             errors;

      function new();
         marker_length = emd_pkg::MARKER_LENGTH_RESET;
         marker_bytes  = emd_pkg::MARKER_BYTES_RESET;
         held_count    = 0;
         skip_zero     = 1'b0;
         errors        = 0;
      endfunction

      function void write_reg(emd_pkg::csr_index_type idx,
                              logic [emd_pkg::CFG_DATA_W-1:0] value);
         if (idx == emd_pkg::CSR_MARKER_LENGTH) begin
            marker_length = value[emd_pkg::CFG_LEN_W-1:0];
         end else begin
            marker_bytes = value;
         end
      endfunction

      function int unsigned active_length();
         int unsigned n;
         n = 32'(marker_length);
         if (n == 0) n = 1;
         if (n > emd_pkg::MAX_MARKER_DEFAULT) n = emd_pkg::MAX_MARKER_DEFAULT;
         return n;
      endfunction

      function logic [emd_pkg::BYTE_W-1:0] marker_byte(int unsigned k);
         if (k >= emd_pkg::CFG_DATA_W / emd_pkg::BYTE_W) return emd_pkg::ZERO_BYTE;
         return marker_bytes[emd_pkg::BYTE_W*k +: emd_pkg::BYTE_W];
      endfunction

      function void push_item(logic [emd_pkg::BYTE_W-1:0] data, logic is_end);
         frame_item_type item;
         item.data   = data;
         item.is_end = is_end;
         expected_q.push_back(item);
      endfunction

      function void release_held();
         for (int unsigned k = 0; k < held_count; k++) push_item(marker_byte(k), 1'b0);
         held_count = 0;
      endfunction

      function void note_byte(logic [emd_pkg::BYTE_W-1:0] value, logic last);
         int unsigned len;
         len = active_length();
         if (skip_zero) begin
            skip_zero = 1'b0;
            if (value == emd_pkg::ZERO_BYTE) return;
         end
         if (held_count >= len) release_held();
         if (value == marker_byte(held_count)) begin
            held_count++;
            if (held_count == len) begin
               held_count = 0;
               push_item(emd_pkg::ZERO_BYTE, 1'b1);
               skip_zero = !last;
            end
            return;
         end
         release_held();
         push_item(value, 1'b0);
      endfunction

      function void check_result(logic [emd_pkg::BYTE_W-1:0] data, logic is_end);
         frame_item_type want;
         if (expected_q.size() == 0) begin
            if (errors < 10) $display("unexpected result: byte %h end %b", data, is_end);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (want.data !== data || want.is_end !== is_end) begin
            if (errors < 10) begin
               $display("mismatch: expected byte %h end %b, got byte %h end %b",
                        want.data, want.is_end, data, is_end);
            end
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   logic [emd_pkg::BYTE_W-1:0]     req_in_byte;
   logic                           req_chunk_last;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [emd_pkg::BYTE_W-1:0]     rsp_out_byte;
   logic                           rsp_is_end;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [0:0]                     csr_index;
   logic [emd_pkg::CFG_DATA_W-1:0] csr_data;

   deframer_scoreboard sb = new();
   int idle_cycles;
   bit quiet;
   bit hold_request;

   end_marker_message_deframer_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_chunk_last (req_chunk_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_end     (rsp_is_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_out_byte, rsp_is_end);
         if (req_valid && !req_stall) sb.note_byte(req_in_byte, req_chunk_last);
         if (csr_valid && csr_ready) begin
            sb.write_reg(emd_pkg::csr_index_type'(csr_index), csr_data);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("end_marker_message_deframer_top_test: FAIL");
      $finish;
   end

   initial begin
      int unsigned wait_cycles;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            wait_cycles  = HOLD_CYCLES;
         end else begin
            wait_cycles = quiet ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_byte(input logic [emd_pkg::BYTE_W-1:0] value, input logic last);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_in_byte    <= value;
      req_chunk_last <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic send_marker(input logic [emd_pkg::CFG_DATA_W-1:0] marker,
                              input int unsigned count, input logic last_on_final);
      for (int unsigned k = 0; k < count; k++) begin
         send_byte(marker[emd_pkg::BYTE_W*k +: emd_pkg::BYTE_W],
                   (k == count - 1) ? last_on_final : 1'b0);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() > 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic config_marker(input logic [emd_pkg::CFG_DATA_W-1:0] length,
                                input logic [emd_pkg::CFG_DATA_W-1:0] marker);
      csr_valid <= 1'b1;
      csr_index <= emd_pkg::CSR_MARKER_LENGTH;
      csr_data  <= length;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_index <= emd_pkg::CSR_MARKER_BYTES;
      csr_data  <= marker;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned                    lengths[10] = '{1, 2, 3, 4, 0, 7, 5, 4, 2, 3};
      logic [emd_pkg::CFG_DATA_W-1:0] marker;
      logic [emd_pkg::BYTE_W-1:0]     value;
      int unsigned                    eff;
      int unsigned                    sent;
      int unsigned                    kind;
      int unsigned                    count;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_in_byte    <= emd_pkg::ZERO_BYTE;
      req_chunk_last <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= emd_pkg::CSR_MARKER_LENGTH;
      csr_data       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Default marker is a single LF byte.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h0A, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h0A, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h0A, 1'b0);
      send_byte(8'h41, 1'b1);
      send_byte(8'h0A, 1'b0);
      send_byte(8'h0A, 1'b0);
      drain();

      config_marker(4, 32'h0A0D_0A0D);
      send_marker(32'h0A0D_0A0D, 3, 1'b0);
      send_byte(8'h0D, 1'b0);
      send_marker(32'h0A0D_0A0D, 4, 1'b0);
      send_byte(8'h00, 1'b0);
      send_marker(32'h0A0D_0A0D, 2, 1'b0);
      drain();

      // Shorten the marker while two bytes are still held back.
      config_marker(2, 32'h0A0D_0A0D);
      send_byte(8'h78, 1'b0);
      drain();

      config_marker(0, 32'hFFFF_FFFF);
      send_byte(8'hFF, 1'b1);
      drain();

      config_marker(7, 32'h0000_0000);
      send_marker(32'h0000_0000, 4, 1'b0);
      send_byte(8'h00, 1'b0);
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase % 4)
            0: marker = $urandom;
            1: begin
               for (int k = 0; k < 4; k++) begin
                  case ($urandom_range(0, 2))
                     0: marker[emd_pkg::BYTE_W*k +: emd_pkg::BYTE_W] = 8'h00;
                     1: marker[emd_pkg::BYTE_W*k +: emd_pkg::BYTE_W] = 8'h0D;
                     default: marker[emd_pkg::BYTE_W*k +: emd_pkg::BYTE_W] = 8'h0A;
                  endcase
               end
            end
            2: begin
               value  = 8'($urandom);
               marker = {4{value}};
            end
            default: marker = (phase == 3) ? 32'hFFFF_FFFF : 32'h0000_0000;
         endcase
         config_marker(lengths[phase], marker);
         eff = lengths[phase];
         if (eff == 0) eff = 1;
         if (eff > emd_pkg::MAX_MARKER_DEFAULT) eff = emd_pkg::MAX_MARKER_DEFAULT;

         quiet = (phase == 2 || phase == 5);
         if (phase == 5) hold_request = 1'b1;

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
               count = $urandom_range(0, 4);
               repeat (count) begin
                  if ($urandom_range(0, 1)) begin
                     value = 8'($urandom);
                  end else begin
                     value = marker[emd_pkg::BYTE_W*$urandom_range(0, 3) +: emd_pkg::BYTE_W];
                  end
                  send_byte(value, 1'($urandom_range(0, 1)));
               end
               send_marker(marker, eff, 1'($urandom_range(0, 1)));
               sent += count + eff;
               if ($urandom_range(0, 1)) begin
                  send_byte(emd_pkg::ZERO_BYTE, 1'($urandom_range(0, 1)));
               end
            end else if (kind <= 7) begin
               count = $urandom_range(0, eff - 1);
               send_marker(marker, count, 1'b0);
               send_byte(8'($urandom), 1'($urandom_range(0, 1)));
               sent += count + 1;
            end else begin
               send_byte(8'($urandom), 1'($urandom_range(0, 1)));
               sent++;
            end
         end
         drain();
      end

      quiet = 1'b0;
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("end_marker_message_deframer_top_test: PASS");
      end else begin
         $display("end_marker_message_deframer_top_test: FAIL");
      end
      $finish;
   end

endmodule
